// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is asserted
`define DCFA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked property, checked during reset as well
`define DCFA_ASSERT_NR(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== rtl/dcfa_pkg.sv =====
package dcfa_pkg;

    localparam int NUM_REGS    = 32;
    localparam int STACK_DEPTH = 4;

    localparam int RIDX_W  = $clog2(NUM_REGS);
    localparam int IDX_W   = $clog2(NUM_REGS + 1);
    localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
    localparam int LVL_IW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SAVE_D  = STACK_DEPTH * NUM_REGS;
    localparam int SAVE_AW = (SAVE_D > 1) ? $clog2(SAVE_D) : 1;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 32;

    localparam logic [CFG_IW-1:0] CFG_CODE_ALIGN = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_DATA_ALIGN = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_TARGET     = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_ADDR_BYTES = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       section;
        logic       first_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic               row_kind;
        logic [5:0]         reg_index;
        logic [2:0]         rule;
        logic signed [63:0] rule_value;
        logic [15:0]        cfa_register;
        logic signed [31:0] cfa_offset;
        logic               cfa_is_expression;
        logic [15:0]        cfa_expr_pos;
        logic               stack_overflow;
        logic               restore_underflow;
        logic               reg_out_of_range;
        logic               last;
    } t_out_word;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_BYTE,
        CMD_PUSH,
        CMD_POP,
        CMD_SNAP,
        CMD_EMIT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op          op;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic pop;
        logic snap;
        logic emit;
    } t_status;

endpackage

// ===== rtl/dcfa_ctrl.sv =====
module dcfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  dcfa_pkg::t_status i_status,
    output dcfa_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import dcfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_DRAIN,
        S_SNAP,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_cnt;
    logic             r_snap_pend;
    logic             r_emit_pend;

    function automatic t_state next_work(input logic snap, input logic emit);
        t_state s;
        if (snap) begin
            s = S_SNAP;
        end else if (emit) begin
            s = S_EMIT;
        end else begin
            s = S_IDLE;
        end
        return s;
    endfunction

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd.idx = r_cnt;
        o_cmd.op  = CMD_IDLE;
        unique case (r_state)
            S_IDLE:  o_cmd.op = i_start ? CMD_BYTE : CMD_IDLE;
            S_PUSH:  o_cmd.op = CMD_PUSH;
            S_POP:   o_cmd.op = CMD_POP;
            S_DRAIN: o_cmd.op = CMD_IDLE;
            S_SNAP:  o_cmd.op = CMD_SNAP;
            S_EMIT:  o_cmd.op = CMD_EMIT;
            default: o_cmd.op = CMD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_snap_pend <= 1'b0;
            r_emit_pend <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_start) begin
                        r_snap_pend <= i_status.snap;
                        r_emit_pend <= i_status.emit;
                        if (i_status.push) begin
                            r_state <= S_PUSH;
                        end else if (i_status.pop) begin
                            r_state <= S_POP;
                        end else begin
                            r_state <= next_work(i_status.snap, i_status.emit);
                        end
                    end
                end
                S_PUSH: begin
                    if (r_cnt == IDX_W'(NUM_REGS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= next_work(r_snap_pend, r_emit_pend);
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_POP: begin
                    if (r_cnt == IDX_W'(NUM_REGS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= next_work(r_snap_pend, r_emit_pend);
                end
                S_SNAP: begin
                    r_snap_pend <= 1'b0;
                    r_cnt       <= '0;
                    r_state     <= r_emit_pend ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (r_cnt == IDX_W'(NUM_REGS)) begin
                        r_cnt       <= '0;
                        r_emit_pend <= 1'b0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/dcfa_dp.sv =====
module dcfa_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dcfa_pkg::t_cmd                i_cmd,
    input  dcfa_pkg::t_in_word            i_word,
    output dcfa_pkg::t_status             o_status,
    output logic                          o_valid,
    output dcfa_pkg::t_out_word           o_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dcfa_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [dcfa_pkg::CFG_DW-1:0]   i_cfg_data
);
    import dcfa_pkg::*;

    typedef enum logic [2:0] {
        PH_OP,
        PH_LEB1,
        PH_LEB2,
        PH_FIXED,
        PH_LEN,
        PH_SKIP
    } t_phase;

    localparam logic [7:0] OP_SET_LOC     = 8'h01;
    localparam logic [7:0] OP_ADV1        = 8'h02;
    localparam logic [7:0] OP_ADV2        = 8'h03;
    localparam logic [7:0] OP_ADV4        = 8'h04;
    localparam logic [7:0] OP_OFS_X       = 8'h05;
    localparam logic [7:0] OP_RESTORE_X   = 8'h06;
    localparam logic [7:0] OP_UNDEF       = 8'h07;
    localparam logic [7:0] OP_SAME        = 8'h08;
    localparam logic [7:0] OP_REGISTER    = 8'h09;
    localparam logic [7:0] OP_REMEMBER    = 8'h0a;
    localparam logic [7:0] OP_RESTORE_ST  = 8'h0b;
    localparam logic [7:0] OP_DEF_CFA     = 8'h0c;
    localparam logic [7:0] OP_DEF_CFA_REG = 8'h0d;
    localparam logic [7:0] OP_DEF_CFA_OFS = 8'h0e;
    localparam logic [7:0] OP_DEF_CFA_EXP = 8'h0f;
    localparam logic [7:0] OP_EXPR        = 8'h10;
    localparam logic [7:0] OP_OFS_X_SF    = 8'h11;
    localparam logic [7:0] OP_DEF_CFA_SF  = 8'h12;
    localparam logic [7:0] OP_CFA_OFS_SF  = 8'h13;
    localparam logic [7:0] OP_VAL_OFS     = 8'h14;
    localparam logic [7:0] OP_VAL_OFS_SF  = 8'h15;
    localparam logic [7:0] OP_VAL_EXPR    = 8'h16;
    localparam logic [7:0] OP_NEG_OFS_X   = 8'h2f;

    localparam logic [1:0] HI_ADV     = 2'b01;
    localparam logic [1:0] HI_OFS     = 2'b10;
    localparam logic [1:0] HI_RESTORE = 2'b11;

    localparam logic [2:0] RULE_SAME     = 3'd0;
    localparam logic [2:0] RULE_UNDEF    = 3'd1;
    localparam logic [2:0] RULE_MEM_OFS  = 3'd2;
    localparam logic [2:0] RULE_REG      = 3'd3;
    localparam logic [2:0] RULE_VAL_OFS  = 3'd4;
    localparam logic [2:0] RULE_MEM_EXPR = 3'd5;
    localparam logic [2:0] RULE_VAL_EXPR = 3'd6;

    localparam int ERR_OVF = 0;
    localparam int ERR_UNF = 1;
    localparam int ERR_REG = 2;

    // configuration
    logic [7:0]        r_caf;
    logic signed [7:0] r_daf;
    logic [31:0]       r_tgt;
    logic [3:0]        r_ab;

    // rule tables
    logic [2:0]  r_kind  [NUM_REGS];
    logic [63:0] r_val   [NUM_REGS];
    logic [2:0]  r_ikind [NUM_REGS];
    logic [63:0] r_ival  [NUM_REGS];

    // remember stack
    logic [66:0] r_save_mem [SAVE_D];
    logic [66:0] r_save_rd;
    logic [64:0] r_scfa [STACK_DEPTH];
    logic        r_pop_wr;
    logic [RIDX_W-1:0] r_pop_idx;
    logic [LVL_IW-1:0] r_sw_lvl;

    // scalar state
    t_phase      r_phase;
    logic [7:0]  r_opcode;
    logic [63:0] r_acc;
    logic [6:0]  r_shift;
    logic [63:0] r_fop;
    logic [31:0] r_code;
    logic [15:0] r_pos;
    logic [15:0] r_skip;
    logic        r_stopped;
    logic [2:0]  r_err;
    logic [15:0] r_cfa_reg;
    logic [31:0] r_cfa_off;
    logic        r_cfa_ex;
    logic [15:0] r_cfa_pos;
    logic [LVL_W-1:0] r_lvl;

    logic        r_out_valid;
    t_out_word   r_out;

    // effective state after section start handling
    logic        byte_go;
    logic        clr;
    t_phase      e_phase;
    logic [7:0]  e_opcode;
    logic [63:0] e_acc;
    logic [6:0]  e_shift;
    logic [63:0] e_fop;
    logic [31:0] e_code;
    logic [15:0] e_pos;
    logic [15:0] e_skip;
    logic        e_stopped;
    logic [2:0]  e_err;
    logic [15:0] e_cfa_reg;
    logic [31:0] e_cfa_off;
    logic        e_cfa_ex;
    logic [15:0] e_cfa_pos;
    logic [LVL_W-1:0] e_lvl;

    t_phase      n_phase;
    logic [7:0]  n_opcode;
    logic [63:0] n_acc;
    logic [6:0]  n_shift;
    logic [63:0] n_fop;
    logic [31:0] n_code;
    logic [15:0] n_pos;
    logic [15:0] n_skip;
    logic        n_stopped;
    logic [2:0]  n_err;
    logic [15:0] n_cfa_reg;
    logic [31:0] n_cfa_off;
    logic        n_cfa_ex;
    logic [15:0] n_cfa_pos;
    logic [LVL_W-1:0] n_lvl;

    logic [7:0]  b;
    logic [7:0]  op;
    logic        leb_sgn;
    logic        leb_done;
    logic [63:0] leb_acc;
    logic [6:0]  leb_shift;
    logic signed [72:0] mul_d;
    logic [63:0] vd;
    logic [3:0]  fx_len;
    logic [63:0] fx_acc;
    logic [6:0]  fx_shift;
    logic [63:0] adv_v;
    logic [63:0] adv_p;
    logic [63:0] adv_t;
    logic [31:0] adv_res;
    logic [LVL_W-1:0] pop_lvl;

    logic        tw_en;
    logic [63:0] tw_r;
    logic [2:0]  tw_kind;
    logic [63:0] tw_val;
    logic        tw_keep;
    logic        tw_rst;
    logic        tw_ok;
    logic [RIDX_W-1:0] tw_idx;
    logic        push_go;
    logic        pop_go;

    logic [RIDX_W-1:0]  sw_idx;
    logic [SAVE_AW-1:0] save_addr;
    logic [IDX_W-1:0]   em_j;
    logic [RIDX_W-1:0]  em_idx;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_word      = r_out;

    assign sw_idx    = i_cmd.idx[RIDX_W-1:0];
    assign save_addr = SAVE_AW'(32'(r_sw_lvl) * NUM_REGS + 32'(sw_idx));
    assign em_j      = i_cmd.idx - 1'b1;
    assign em_idx    = em_j[RIDX_W-1:0];

    always_comb begin
        byte_go   = (i_cmd.op == CMD_BYTE);
        clr       = i_word.first_byte && !i_word.section;
        e_phase   = i_word.first_byte ? PH_OP : r_phase;
        e_stopped = i_word.first_byte ? 1'b0 : r_stopped;
        e_code    = i_word.first_byte ? 32'd0 : r_code;
        e_opcode  = clr ? 8'd0 : r_opcode;
        e_acc     = clr ? 64'd0 : r_acc;
        e_shift   = clr ? 7'd0 : r_shift;
        e_fop     = clr ? 64'd0 : r_fop;
        e_pos     = clr ? 16'd0 : r_pos;
        e_skip    = clr ? 16'd0 : r_skip;
        e_err     = clr ? 3'd0 : r_err;
        e_cfa_reg = clr ? 16'd0 : r_cfa_reg;
        e_cfa_off = clr ? 32'd0 : r_cfa_off;
        e_cfa_ex  = clr ? 1'b0 : r_cfa_ex;
        e_cfa_pos = clr ? 16'd0 : r_cfa_pos;
        e_lvl     = clr ? '0 : r_lvl;

        b  = i_word.data_byte;
        op = e_opcode;

        // leb128 byte
        leb_sgn = (e_phase == PH_LEB2) &&
                  ((op == OP_OFS_X_SF) || (op == OP_DEF_CFA_SF) ||
                   (op == OP_CFA_OFS_SF) || (op == OP_VAL_OFS_SF));
        leb_done  = !b[7];
        leb_acc   = e_acc;
        leb_shift = e_shift;
        if (e_shift < 7'd64) begin
            leb_acc   = e_acc | (64'(b[6:0]) << e_shift[5:0]);
            leb_shift = e_shift + 7'd7;
        end
        if (leb_done && leb_sgn && b[6] && (leb_shift < 7'd64)) begin
            leb_acc = leb_acc | ({64{1'b1}} << leb_shift[5:0]);
        end
        mul_d = $signed({1'b0, leb_acc}) * r_daf;
        vd    = mul_d[63:0];

        // fixed-size operand byte
        case (op)
            OP_ADV1: fx_len = 4'd1;
            OP_ADV2: fx_len = 4'd2;
            OP_ADV4: fx_len = 4'd4;
            default: begin
                if (r_ab == 4'd0) begin
                    fx_len = 4'd1;
                end else if (r_ab > 4'd8) begin
                    fx_len = 4'd8;
                end else begin
                    fx_len = r_ab;
                end
            end
        endcase
        fx_acc = e_acc;
        if (e_shift < 7'd8) begin
            fx_acc = e_acc | (64'(b) << {e_shift[2:0], 3'b000});
        end
        fx_shift = e_shift + 7'd1;

        adv_v   = (e_phase == PH_FIXED) ? fx_acc : 64'(b[5:0]);
        adv_p   = adv_v * 64'(r_caf);
        adv_t   = 64'(e_code) + adv_p;
        adv_res = (|adv_t[63:32]) ? 32'hFFFF_FFFF : adv_t[31:0];

        pop_lvl = e_lvl - 1'b1;

        n_phase   = e_phase;
        n_opcode  = e_opcode;
        n_acc     = e_acc;
        n_shift   = e_shift;
        n_fop     = e_fop;
        n_code    = e_code;
        n_pos     = e_pos + 16'd1;
        n_skip    = e_skip;
        n_stopped = e_stopped;
        n_err     = e_err;
        n_cfa_reg = e_cfa_reg;
        n_cfa_off = e_cfa_off;
        n_cfa_ex  = e_cfa_ex;
        n_cfa_pos = e_cfa_pos;
        n_lvl     = e_lvl;

        tw_en   = 1'b0;
        tw_r    = e_fop;
        tw_kind = RULE_SAME;
        tw_val  = 64'd0;
        tw_keep = 1'b0;
        tw_rst  = 1'b0;
        push_go = 1'b0;
        pop_go  = 1'b0;

        unique case (e_phase)
            PH_FIXED: begin
                n_acc   = fx_acc;
                n_shift = fx_shift;
                if (fx_shift >= 7'(fx_len)) begin
                    if (op == OP_SET_LOC) begin
                        n_code = (|fx_acc[63:32]) ? 32'hFFFF_FFFF : fx_acc[31:0];
                    end else begin
                        n_code = adv_res;
                    end
                    n_phase = PH_OP;
                end
            end
            PH_LEB1: begin
                n_acc   = leb_acc;
                n_shift = leb_shift;
                if (leb_done) begin
                    n_fop = leb_acc;
                    tw_r  = leb_acc;
                    case (op) inside
                        OP_RESTORE_X: begin
                            tw_en   = 1'b1;
                            tw_rst  = 1'b1;
                            n_phase = PH_OP;
                        end
                        OP_UNDEF: begin
                            tw_en   = 1'b1;
                            tw_kind = RULE_UNDEF;
                            tw_keep = 1'b1;
                            n_phase = PH_OP;
                        end
                        OP_SAME: begin
                            tw_en   = 1'b1;
                            tw_kind = RULE_SAME;
                            tw_keep = 1'b1;
                            n_phase = PH_OP;
                        end
                        OP_DEF_CFA_REG: begin
                            n_cfa_reg = leb_acc[15:0];
                            n_cfa_ex  = 1'b0;
                            n_phase   = PH_OP;
                        end
                        OP_EXPR, OP_VAL_EXPR: begin
                            n_skip  = e_pos + 16'd1;
                            n_acc   = 64'd0;
                            n_shift = 7'd0;
                            n_phase = PH_LEN;
                        end
                        default: begin
                            n_acc   = 64'd0;
                            n_shift = 7'd0;
                            n_phase = PH_LEB2;
                        end
                    endcase
                end
            end
            PH_LEB2: begin
                n_acc   = leb_acc;
                n_shift = leb_shift;
                if (leb_done) begin
                    n_phase = PH_OP;
                    if (op[7:6] == HI_OFS) begin
                        tw_en   = 1'b1;
                        tw_r    = 64'(op[5:0]);
                        tw_kind = RULE_MEM_OFS;
                        tw_val  = vd;
                    end else begin
                        case (op) inside
                            OP_OFS_X, OP_OFS_X_SF: begin
                                tw_en   = 1'b1;
                                tw_kind = RULE_MEM_OFS;
                                tw_val  = vd;
                            end
                            OP_REGISTER: begin
                                tw_en   = 1'b1;
                                tw_kind = RULE_REG;
                                tw_val  = leb_acc;
                            end
                            OP_DEF_CFA: begin
                                n_cfa_reg = e_fop[15:0];
                                n_cfa_off = leb_acc[31:0];
                                n_cfa_ex  = 1'b0;
                            end
                            OP_DEF_CFA_SF: begin
                                n_cfa_reg = e_fop[15:0];
                                n_cfa_off = vd[31:0];
                                n_cfa_ex  = 1'b0;
                            end
                            OP_DEF_CFA_OFS: n_cfa_off = leb_acc[31:0];
                            OP_CFA_OFS_SF:  n_cfa_off = vd[31:0];
                            OP_VAL_OFS, OP_VAL_OFS_SF: begin
                                tw_en   = 1'b1;
                                tw_kind = RULE_VAL_OFS;
                                tw_val  = vd;
                            end
                            OP_NEG_OFS_X: begin
                                tw_en   = 1'b1;
                                tw_kind = RULE_MEM_OFS;
                                tw_val  = 64'd0 - leb_acc;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            PH_LEN: begin
                n_acc   = leb_acc;
                n_shift = leb_shift;
                if (leb_done) begin
                    if (op == OP_DEF_CFA_EXP) begin
                        n_cfa_reg = 16'd0;
                        n_cfa_ex  = 1'b1;
                        n_cfa_pos = e_skip;
                    end else begin
                        tw_en   = 1'b1;
                        tw_kind = (op == OP_EXPR) ? RULE_MEM_EXPR : RULE_VAL_EXPR;
                        tw_val  = 64'(e_skip);
                    end
                    n_skip  = (|leb_acc[63:16]) ? 16'hFFFF : leb_acc[15:0];
                    n_phase = (n_skip != 16'd0) ? PH_SKIP : PH_OP;
                end
            end
            PH_SKIP: begin
                n_skip = e_skip - 16'd1;
                if (e_skip == 16'd1) begin
                    n_phase = PH_OP;
                end
            end
            default: begin
                n_phase = PH_OP;
                if (e_stopped) begin
                    n_stopped = 1'b1;
                end else if (e_code >= r_tgt) begin
                    n_stopped = 1'b1;
                end else begin
                    n_opcode = b;
                    n_acc    = 64'd0;
                    n_shift  = 7'd0;
                    unique case (b[7:6])
                        HI_ADV: begin
                            n_code = adv_res;
                            n_acc  = e_acc;
                            n_shift = e_shift;
                        end
                        HI_OFS: n_phase = PH_LEB2;
                        HI_RESTORE: begin
                            tw_en  = 1'b1;
                            tw_rst = 1'b1;
                            tw_r   = 64'(b[5:0]);
                            n_acc  = e_acc;
                            n_shift = e_shift;
                        end
                        default: begin
                            case (b) inside
                                OP_SET_LOC, OP_ADV1, OP_ADV2, OP_ADV4: n_phase = PH_FIXED;
                                OP_OFS_X, OP_RESTORE_X, OP_UNDEF, OP_SAME, OP_REGISTER,
                                OP_DEF_CFA, OP_DEF_CFA_REG, OP_EXPR, OP_OFS_X_SF,
                                OP_DEF_CFA_SF, OP_VAL_OFS, OP_VAL_OFS_SF, OP_VAL_EXPR,
                                OP_NEG_OFS_X: n_phase = PH_LEB1;
                                OP_DEF_CFA_OFS, OP_CFA_OFS_SF: n_phase = PH_LEB2;
                                OP_DEF_CFA_EXP: begin
                                    n_skip  = e_pos + 16'd1;
                                    n_phase = PH_LEN;
                                end
                                OP_REMEMBER: begin
                                    n_acc   = e_acc;
                                    n_shift = e_shift;
                                    if (e_lvl >= LVL_W'(STACK_DEPTH)) begin
                                        n_err[ERR_OVF] = 1'b1;
                                    end else begin
                                        push_go = 1'b1;
                                        n_lvl   = e_lvl + 1'b1;
                                    end
                                end
                                OP_RESTORE_ST: begin
                                    n_acc   = e_acc;
                                    n_shift = e_shift;
                                    if (e_lvl == '0) begin
                                        n_err[ERR_UNF] = 1'b1;
                                    end else begin
                                        pop_go    = 1'b1;
                                        n_lvl     = pop_lvl;
                                        n_cfa_reg = r_scfa[pop_lvl[LVL_IW-1:0]][15:0];
                                        n_cfa_off = r_scfa[pop_lvl[LVL_IW-1:0]][47:16];
                                        n_cfa_ex  = r_scfa[pop_lvl[LVL_IW-1:0]][48];
                                        n_cfa_pos = r_scfa[pop_lvl[LVL_IW-1:0]][64:49];
                                    end
                                end
                                default: begin
                                    n_acc   = e_acc;
                                    n_shift = e_shift;
                                end
                            endcase
                        end
                    endcase
                end
            end
        endcase

        if (i_word.last_byte) begin
            n_phase = PH_OP;
        end

        tw_ok  = (tw_r < 64'(NUM_REGS));
        tw_idx = tw_r[RIDX_W-1:0];
        if (tw_en && !tw_ok) begin
            n_err[ERR_REG] = 1'b1;
        end

        o_status.push = push_go;
        o_status.pop  = pop_go;
        o_status.snap = i_word.last_byte && !i_word.section;
        o_status.emit = i_word.last_byte && i_word.section;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caf <= 8'd1;
            r_daf <= -8'sd8;
            r_tgt <= 32'd0;
            r_ab  <= 4'd8;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CODE_ALIGN: r_caf <= i_cfg_data[7:0];
                CFG_DATA_ALIGN: r_daf <= i_cfg_data[7:0];
                CFG_TARGET:     r_tgt <= i_cfg_data[31:0];
                CFG_ADDR_BYTES: r_ab  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OP;
            r_opcode  <= '0;
            r_acc     <= '0;
            r_shift   <= '0;
            r_fop     <= '0;
            r_code    <= '0;
            r_pos     <= '0;
            r_skip    <= '0;
            r_stopped <= 1'b0;
            r_err     <= '0;
            r_cfa_reg <= '0;
            r_cfa_off <= '0;
            r_cfa_ex  <= 1'b0;
            r_cfa_pos <= '0;
            r_lvl     <= '0;
            r_sw_lvl  <= '0;
        end else if (byte_go) begin
            r_phase   <= n_phase;
            r_opcode  <= n_opcode;
            r_acc     <= n_acc;
            r_shift   <= n_shift;
            r_fop     <= n_fop;
            r_code    <= n_code;
            r_pos     <= n_pos;
            r_skip    <= n_skip;
            r_stopped <= n_stopped;
            r_err     <= n_err;
            r_cfa_reg <= n_cfa_reg;
            r_cfa_off <= n_cfa_off;
            r_cfa_ex  <= n_cfa_ex;
            r_cfa_pos <= n_cfa_pos;
            r_lvl     <= n_lvl;
            if (push_go) begin
                r_sw_lvl <= e_lvl[LVL_IW-1:0];
            end else if (pop_go) begin
                r_sw_lvl <= pop_lvl[LVL_IW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_go && push_go) begin
            r_scfa[e_lvl[LVL_IW-1:0]] <= {e_cfa_pos, e_cfa_ex, e_cfa_off, e_cfa_reg};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_PUSH) begin
            r_save_mem[save_addr] <= {r_kind[sw_idx], r_val[sw_idx]};
        end
        if (i_cmd.op == CMD_POP) begin
            r_save_rd <= r_save_mem[save_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop_wr  <= 1'b0;
            r_pop_idx <= '0;
        end else begin
            r_pop_wr  <= (i_cmd.op == CMD_POP);
            r_pop_idx <= sw_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (byte_go && clr)) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_kind[i]  <= RULE_SAME;
                r_val[i]   <= '0;
                r_ikind[i] <= RULE_SAME;
                r_ival[i]  <= '0;
            end
        end else if (byte_go && tw_en && tw_ok) begin
            if (tw_rst) begin
                r_kind[tw_idx] <= r_ikind[tw_idx];
                r_val[tw_idx]  <= r_ival[tw_idx];
            end else begin
                r_kind[tw_idx] <= tw_kind;
                if (!tw_keep) begin
                    r_val[tw_idx] <= tw_val;
                end
            end
        end else if (i_cmd.op == CMD_SNAP) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_ikind[i] <= r_kind[i];
                r_ival[i]  <= r_val[i];
            end
        end else if (r_pop_wr) begin
            r_kind[r_pop_idx] <= r_save_rd[66:64];
            r_val[r_pop_idx]  <= r_save_rd[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_cmd.op == CMD_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_EMIT) begin
            r_out                   <= '0;
            r_out.stack_overflow    <= r_err[ERR_OVF];
            r_out.restore_underflow <= r_err[ERR_UNF];
            r_out.reg_out_of_range  <= r_err[ERR_REG];
            r_out.last              <= (i_cmd.idx == IDX_W'(NUM_REGS));
            if (i_cmd.idx == '0) begin
                r_out.cfa_register      <= r_cfa_reg;
                r_out.cfa_offset        <= r_cfa_off;
                r_out.cfa_is_expression <= r_cfa_ex;
                r_out.cfa_expr_pos      <= r_cfa_ex ? r_cfa_pos : 16'd0;
            end else begin
                r_out.row_kind   <= 1'b1;
                r_out.reg_index  <= 6'(em_j);
                r_out.rule       <= r_kind[em_idx];
                r_out.rule_value <= r_val[em_idx];
            end
        end
    end

endmodule

// ===== rtl/dwarf_cfa_rule_interpreter.sv =====
// Call-frame rule interpreter: takes one instruction byte per cycle while busy
// is low (CIE bytes, then FDE bytes). A remember_state or restore_state that
// neither overflows nor underflows the stack holds busy while the rule copy
// goes one register a cycle through the single-port stack memory, and
// restore_state adds a drain step. The last CIE byte adds a rule snapshot. The
// last FDE byte starts NUM_REGS + 1 rows, CFA row first, on o_valid in
// consecutive cycles from the emit state; each row is on the port for one
// cycle only, since the receiver cannot stall, and the final row has last set.
module dwarf_cfa_rule_interpreter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  dcfa_pkg::t_in_word          i_word,
    output logic                        o_valid,
    output dcfa_pkg::t_out_word         o_word,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dcfa_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [dcfa_pkg::CFG_DW-1:0] i_cfg_data
);
    import dcfa_pkg::*;

    t_cmd    cmd;
    t_status status;

    dcfa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    dcfa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_word      (i_word),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_word      (o_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// ===== rtl/dcfa_checker.sv =====
`include "assert_macros.svh"

module dcfa_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input dcfa_pkg::t_in_word  i_word,
    input logic                o_valid,
    input dcfa_pkg::t_out_word o_word
);
    import dcfa_pkg::*;

    `DCFA_ASSERT_NR(a_reset_quiet, i_clk, !i_rst_n |=> (!o_valid && !busy), "not quiet after reset")
    `DCFA_ASSERT(a_fde_end_busy, i_clk, i_rst_n, (start && !busy && i_word.last_byte && i_word.section) |=> busy, "no busy after fde end")
    `DCFA_ASSERT(a_rows_back_to_back, i_clk, i_rst_n, (o_valid && !o_word.last) |=> o_valid, "gap in row run")
    `DCFA_ASSERT(a_run_ends, i_clk, i_rst_n, (o_valid && o_word.last) |=> !o_valid, "row after final row")
    `DCFA_ASSERT(a_cfa_first, i_clk, i_rst_n, $rose(o_valid) |-> (o_word.row_kind == 1'b0), "run does not open with cfa row")

endmodule

bind dwarf_cfa_rule_interpreter dcfa_checker u_dcfa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_word  (i_word),
    .o_valid (o_valid),
    .o_word  (o_word)
);
